FILE: sv/matrix_matrix_multiply_assert.svh
// ============================================================================
// Matrix multiply assertion macros
// Shared concurrent checks, written as one-line macro uses in the RTL.
// ============================================================================
`ifndef MATRIX_MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MATRIX_MULTIPLY_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix multiply check failed");

// Check that cons holds in the cycle after ante.
`define MMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix multiply check failed");

`endif

FILE: sv/mmm_pkg.sv
// ============================================================================
// Matrix multiply package
// Widths, codes and control structs shared by the matrix multiply modules.
// ============================================================================
package mmm_pkg;

    // Default sizes
    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    // Field widths of the channels
    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 3;
    localparam int IN_ELEM_W  = 16;
    localparam int PROD_W     = 35;

    // Packed channel widths
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;
    localparam int M_PAD_W    = M_TDATA_W - PROD_W - 2 * ROW_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROWS_A  = 2'd0,
        REG_INNER_A = 2'd1,
        REG_ROWS_B  = 2'd2,
        REG_COLS_B  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_DRAIN,
        ST_ERR
    } state_t;

    // Matrix sizes as written by the configuration port
    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_a;
        logic [CFG_W-1:0] rows_b;
        logic [CFG_W-1:0] cols_b;
    } dims_t;

    // Tag that travels with an element of A along the cell chain
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] t;
    } chain_ctl_t;

    // Result chain control
    typedef struct packed {
        logic capture;
        logic shift;
    } drain_ctl_t;

    // Write of one element of B
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } b_wr_t;

endpackage

FILE: sv/mmm_cell.sv
// ============================================================================
// Matrix multiply cell
// Holds one column of B, multiplies the passing elements of A against it,
// accumulates one element of C and takes part in the result shift chain.
// ============================================================================
module mmm_cell #(
    parameter int MAX_DIM    = mmm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mmm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // column store write
    input  logic                          b_we,
    input  logic [mmm_pkg::ROW_W-1:0]     b_row,
    input  logic signed [ELEM_WIDTH-1:0]  b_data,
    // element stream from the left neighbor, passed on to the right
    input  mmm_pkg::chain_ctl_t           ctl_in,
    input  logic signed [ELEM_WIDTH-1:0]  a_in,
    output mmm_pkg::chain_ctl_t           ctl_out,
    output logic signed [ELEM_WIDTH-1:0]  a_out,
    // result chain, shifts toward the head cell
    input  mmm_pkg::drain_ctl_t           drain,
    input  logic [mmm_pkg::PROD_W-1:0]    res_in,
    output logic [mmm_pkg::PROD_W-1:0]    res_out,
    output logic                          done
);
    import mmm_pkg::*;

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MUL_W = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0] b_col_reg [MAX_DIM];
    chain_ctl_t                   ctl_reg;
    logic signed [ELEM_WIDTH-1:0] a_reg;
    logic signed [MUL_W-1:0]      mul_reg;
    logic [PROD_W-1:0]            acc_reg;
    logic [PROD_W-1:0]            acc_next;
    logic [PROD_W-1:0]            mul_ext;
    logic                         done_reg;
    logic [PROD_W-1:0]            res_reg;

    // Column store
    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_col_reg[b_row[IDX_W-1:0]] <= b_data;
        end
    end

    // Stage one: multiply and hold the tag for the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_in;
        mul_reg <= a_in * b_col_reg[ctl_in.t[IDX_W-1:0]];
    end

    // Stage two: accumulate, restart on the first term of a row
    assign mul_ext  = PROD_W'(mul_reg);
    assign acc_next = ctl_reg.first ? mul_ext : acc_reg + mul_ext;

    always_ff @(posedge aclk) begin
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= ctl_reg.valid && ctl_reg.last;
        end
    end

    // Result chain: capture the sum, then shift toward the head
    always_ff @(posedge aclk) begin
        if (drain.capture) begin
            res_reg <= acc_reg;
        end else if (drain.shift) begin
            res_reg <= res_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign res_out = res_reg;
    assign done    = done_reg;

endmodule

FILE: sv/mmm_ctrl.sv
// ============================================================================
// Matrix multiply controller
// Decodes commands, holds matrix A, feeds its rows into the cell chain and
// drains finished rows of C into the output register.
// ============================================================================
`include "matrix_matrix_multiply_assert.svh"

module mmm_ctrl #(
    parameter int MAX_DIM    = mmm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mmm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mmm_pkg::dims_t                    dims,
    // command side
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mmm_pkg::CMD_W-1:0]         in_cmd,
    input  logic [mmm_pkg::ROW_W-1:0]         in_row,
    input  logic [mmm_pkg::ROW_W-1:0]         in_col,
    input  logic signed [mmm_pkg::IN_ELEM_W-1:0] in_elem,
    // cell chain
    output mmm_pkg::b_wr_t                    b_wr,
    output logic signed [ELEM_WIDTH-1:0]      wr_elem,
    output mmm_pkg::chain_ctl_t               feed_ctl,
    output logic signed [ELEM_WIDTH-1:0]      feed_a,
    output mmm_pkg::drain_ctl_t               drain,
    input  logic [mmm_pkg::PROD_W-1:0]        res_head,
    input  logic                              tail_done,
    // result side
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mmm_pkg::ROW_W-1:0]         out_row,
    output logic [mmm_pkg::ROW_W-1:0]         out_col,
    output logic [mmm_pkg::PROD_W-1:0]        out_product,
    output logic                              out_error,
    output logic                              out_last
);
    import mmm_pkg::*;

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

    state_t                       state_reg, state_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [ROW_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             t_reg, t_next;

    logic [CFG_W-1:0]             ra, ia, rb, cb;
    logic                         size_bad;
    logic                         accept;
    logic                         ld_a;
    logic                         t_last, row_last, col_last;
    logic                         rd_en;
    logic                         out_free;
    logic                         out_load;
    logic                         out_err_next;
    logic                         out_last_next;

    logic signed [ELEM_WIDTH-1:0] a_mem [MAX_DIM * MAX_DIM];
    logic [ADDR_W-1:0]            wr_addr, rd_addr;
    logic signed [ELEM_WIDTH-1:0] a_rd_reg;
    chain_ctl_t                   feed_ctl_reg;

    logic                         out_valid_reg;
    logic [ROW_W-1:0]             out_row_reg, out_col_reg;
    logic [PROD_W-1:0]            out_prod_reg;
    logic                         out_err_reg, out_last_reg;

    // Clamp sizes to the array dimension
    assign ra = (dims.rows_a  > DIM_MAX) ? DIM_MAX : dims.rows_a;
    assign ia = (dims.inner_a > DIM_MAX) ? DIM_MAX : dims.inner_a;
    assign rb = (dims.rows_b  > DIM_MAX) ? DIM_MAX : dims.rows_b;
    assign cb = (dims.cols_b  > DIM_MAX) ? DIM_MAX : dims.cols_b;

    assign size_bad = (ia != rb) || (ra == '0) || (ia == '0) || (cb == '0);

    // Load decode; writes outside the sizes drop
    assign accept  = in_valid && in_ready;
    assign ld_a    = accept && (in_cmd == CMD_LOAD_A)
                     && (CFG_W'(in_row) < ra) && (CFG_W'(in_col) < ia);
    assign b_wr.en  = accept && (in_cmd == CMD_LOAD_B)
                     && (CFG_W'(in_row) < rb) && (CFG_W'(in_col) < cb);
    assign b_wr.row = in_row;
    assign b_wr.col = in_col;
    assign wr_elem  = ELEM_WIDTH'(in_elem);

    // Loop ends
    assign t_last   = (CFG_W'(t_reg)   == ia - CFG_W'(1));
    assign row_last = (CFG_W'(row_reg) == ra - CFG_W'(1));
    assign col_last = (CFG_W'(col_reg) == cb - CFG_W'(1));

    assign out_free = !out_valid_reg || out_ready;

    // Store of A: one write port, one registered read port
    assign wr_addr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
    assign rd_addr = ADDR_W'(row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(t_reg);

    always_ff @(posedge aclk) begin
        if (ld_a) begin
            a_mem[wr_addr] <= wr_elem;
        end
        a_rd_reg <= a_mem[rd_addr];
    end

    // Tag aligned with the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feed_ctl_reg <= '0;
        end else begin
            feed_ctl_reg.valid <= rd_en;
            feed_ctl_reg.first <= (t_reg == '0);
            feed_ctl_reg.last  <= t_last;
            feed_ctl_reg.t     <= t_reg;
        end
    end

    assign feed_ctl = feed_ctl_reg;
    assign feed_a   = a_rd_reg;

    // State and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            t_reg     <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            t_reg     <= t_next;
        end
    end

    // Next state: feed a row, wait for the chain, drain the row; a size error gives one error item
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        t_next        = t_reg;
        in_ready      = 1'b0;
        rd_en         = 1'b0;
        drain         = '0;
        out_load      = 1'b0;
        out_err_next  = 1'b0;
        out_last_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid && (in_cmd == CMD_COMPUTE)) begin
                    if (size_bad) begin
                        state_next = ST_ERR;
                    end else begin
                        row_next   = '0;
                        col_next   = '0;
                        t_next     = '0;
                        state_next = ST_FEED;
                    end
                end
            end
            ST_FEED: begin
                rd_en = 1'b1;
                if (t_last) begin
                    t_next     = '0;
                    state_next = ST_WAIT;
                end else begin
                    t_next = t_reg + ROW_W'(1);
                end
            end
            ST_WAIT: begin
                if (tail_done) begin
                    drain.capture = 1'b1;
                    col_next      = '0;
                    state_next    = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    drain.shift   = 1'b1;
                    out_last_next = row_last && col_last;
                    if (col_last) begin
                        col_next = '0;
                        if (row_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            row_next   = row_reg + ROW_W'(1);
                            state_next = ST_FEED;
                        end
                    end else begin
                        col_next = col_reg + ROW_W'(1);
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_err_next  = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg  <= out_err_next ? '0 : row_reg;
            out_col_reg  <= out_err_next ? '0 : col_reg;
            out_prod_reg <= out_err_next ? '0 : res_head;
            out_err_reg  <= out_err_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_product = out_prod_reg;
    assign out_error   = out_err_reg;
    assign out_last    = out_last_reg;

    // Checks
    `MMM_ASSERT_SAME(a_done_only_waiting, aclk, aresetn, tail_done, state_reg == ST_WAIT)
    `MMM_ASSERT_NEXT(a_feed_tag_follows, aclk, aresetn, state_reg == ST_FEED, feed_ctl_reg.valid)
    `MMM_ASSERT_NEXT(a_run_ends_idle, aclk, aresetn, out_load && out_last_next, state_reg == ST_IDLE)

endmodule

FILE: sv/matrix_matrix_multiply.sv
// ============================================================================
// Matrix multiply C = A x B
// Signed Q8.8 elements, exact Q19.16 results, one cell per column of B.
// ============================================================================
// Usage:
//   Sizes are set on the cfg port (rows_a, inner_a, rows_b, cols_b) while
//   the block is idle; each write takes effect at once.
//   s_ items carry a command in s_tuser: load A, load B or compute. A load
//   stores one element; a load outside the sizes is dropped.
//   A compute item streams every element of C on m_ in row-major order,
//   m_tlast on the final one. An inner size mismatch or a zero size gives a
//   single item with m_tuser set instead.
//   Each row of C is computed in turn: the row of A is read from the store,
//   the element stream crosses the cell chain, then the row is shifted out
//   one element of C per item. The next row starts only after the last one
//   has drained. The A store has one read port and there is a single result
//   chain.
//   s_tready is high only between compute runs.
//   A stalled m_tready holds the current result and freezes the drain.
//   Reset sets all sizes to 1 and empties the output register; stored
//   elements are undefined until written.
// ============================================================================
module matrix_matrix_multiply #(
    parameter int MAX_DIM    = mmm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mmm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mmm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mmm_pkg::CFG_W-1:0]         cfg_wr_data,
    // command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mmm_pkg::S_TDATA_W-1:0]     s_tdata,  // row[2:0], col[5:3], element[21:6]
    input  logic [mmm_pkg::S_TUSER_W-1:0]     s_tuser,  // command[1:0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mmm_pkg::M_TDATA_W-1:0]     m_tdata,  // out_row[2:0], out_col[5:3],
                                                        // product[40:6]
    output logic [mmm_pkg::M_TUSER_W-1:0]     m_tuser,  // size_error[0]
    output logic                              m_tlast
);
    import mmm_pkg::*;

    dims_t                        dims_reg;

    b_wr_t                        b_wr;
    logic signed [ELEM_WIDTH-1:0] wr_elem;
    drain_ctl_t                   drain;
    chain_ctl_t                   ctl_w [MAX_DIM + 1];
    logic signed [ELEM_WIDTH-1:0] a_w   [MAX_DIM + 1];
    logic [PROD_W-1:0]            res_w [MAX_DIM + 1];
    logic                         done_w [MAX_DIM];

    logic [ROW_W-1:0]             out_row, out_col;
    logic [PROD_W-1:0]            out_product;
    logic                         out_error;

    // Size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.rows_a  <= CFG_W'(1);
            dims_reg.inner_a <= CFG_W'(1);
            dims_reg.rows_b  <= CFG_W'(1);
            dims_reg.cols_b  <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_ROWS_A:  dims_reg.rows_a  <= cfg_wr_data;
                REG_INNER_A: dims_reg.inner_a <= cfg_wr_data;
                REG_ROWS_B:  dims_reg.rows_b  <= cfg_wr_data;
                REG_COLS_B:  dims_reg.cols_b  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Controller with the A store and output register
    mmm_ctrl #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dims        (dims_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser[CMD_W-1:0]),
        .in_row      (s_tdata[ROW_W-1:0]),
        .in_col      (s_tdata[2*ROW_W-1:ROW_W]),
        .in_elem     (s_tdata[2*ROW_W+IN_ELEM_W-1:2*ROW_W]),
        .b_wr        (b_wr),
        .wr_elem     (wr_elem),
        .feed_ctl    (ctl_w[0]),
        .feed_a      (a_w[0]),
        .drain       (drain),
        .res_head    (res_w[0]),
        .tail_done   (done_w[MAX_DIM-1]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_product (out_product),
        .out_error   (out_error),
        .out_last    (m_tlast)
    );

    // Cell chain: elements of A move right, results shift left
    assign res_w[MAX_DIM] = '0;

    for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
        mmm_cell #(
            .MAX_DIM    (MAX_DIM),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .b_we    (b_wr.en && (b_wr.col == ROW_W'(j))),
            .b_row   (b_wr.row),
            .b_data  (wr_elem),
            .ctl_in  (ctl_w[j]),
            .a_in    (a_w[j]),
            .ctl_out (ctl_w[j+1]),
            .a_out   (a_w[j+1]),
            .drain   (drain),
            .res_in  (res_w[j+1]),
            .res_out (res_w[j]),
            .done    (done_w[j])
        );
    end

    // Pack the result item
    assign m_tdata = {{M_PAD_W{1'b0}}, out_product, out_col, out_row};
    assign m_tuser = out_error;

endmodule
